### hdl/kte_pkg.sv
package kte_pkg;

  localparam int MAX_K         = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int VALUE_W       = 14;
  localparam int LEN_W         = 3;
  localparam int ID_W          = 16;

  localparam logic [2:0]  K_SIZE_RESET = 3'd4;
  localparam logic        REG_K_SIZE   = 1'b0;
  localparam logic [15:0] ID_UNKNOWN   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_t;

  typedef struct packed {
    logic signed [15:0] token_id;
    logic               last_of_run;
    logic               end_of_sequence;
  } out_t;

  // up to two results per request, second only together with the first
  typedef struct packed {
    logic push0;
    logic push1;
    out_t entry0;
    out_t entry1;
  } push_t;

  // sum of 5^1 .. 5^(L-1) plus the five special ids
  function automatic logic [15:0] len_offset(input logic [2:0] len);
    logic [15:0] off;
    case (len)
      3'd1:    off = 16'd5;
      3'd2:    off = 16'd10;
      3'd3:    off = 16'd35;
      3'd4:    off = 16'd160;
      3'd5:    off = 16'd785;
      3'd6:    off = 16'd3910;
      default: off = 16'd0;
    endcase
    return off;
  endfunction

  // {marker, code}
  function automatic logic [3:0] special_code(input logic [7:0] s);
    logic [3:0] r;
    case (s)
      8'h4D:   r = {1'b1, 3'd0};
      8'h50:   r = {1'b1, 3'd1};
      8'h42:   r = {1'b1, 3'd2};
      8'h53:   r = {1'b1, 3'd3};
      8'h45:   r = {1'b1, 3'd4};
      default: r = {1'b0, 3'd0};
    endcase
    return r;
  endfunction

  // {is_base, digit}
  function automatic logic [3:0] base_digit(input logic [7:0] s);
    logic [3:0] r;
    case (s)
      8'h41:   r = {1'b1, 3'd0};
      8'h54:   r = {1'b1, 3'd1};
      8'h47:   r = {1'b1, 3'd2};
      8'h43:   r = {1'b1, 3'd3};
      8'h0A:   r = {1'b1, 3'd4};
      default: r = {1'b0, 3'd0};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] chunk_id(input logic [13:0] value, input logic [2:0] len,
                                           input logic unknown);
    logic [15:0] id;
    if (unknown || len == 3'd0 || len > 3'd6) begin
      id = ID_UNKNOWN;
    end else begin
      id = len_offset(len) + {2'b00, value};
    end
    return id;
  endfunction

endpackage

### hdl/kte_front.sv
module kte_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  kte_pkg::in_t    in_item,
  input  logic [2:0]      k_size,
  input  logic            cfg_clear,
  output kte_pkg::push_t  push
);

  logic [13:0] chunk_value_r, chunk_value_nxt;
  logic [2:0]  chunk_length_r, chunk_length_nxt;
  logic        chunk_unknown_r, chunk_unknown_nxt;

  logic [3:0]  sp;
  logic [3:0]  bd;
  logic [2:0]  eff_k;
  logic [15:0] scaled;
  logic [13:0] new_value;
  logic [2:0]  new_length;
  logic        new_unknown;
  logic        emit;

  always_comb begin
    sp = kte_pkg::special_code(in_item.symbol);
    bd = kte_pkg::base_digit(in_item.symbol);

    if (k_size == 3'd0) begin
      eff_k = 3'd1;
    end else if (k_size > 3'(kte_pkg::MAX_K)) begin
      eff_k = 3'(kte_pkg::MAX_K);
    end else begin
      eff_k = k_size;
    end

    // value * 5 + digit, kept to the state width
    scaled      = {chunk_value_r, 2'b00} + {2'b00, chunk_value_r} + {13'd0, bd[2:0]};
    new_value   = bd[3] ? scaled[13:0] : chunk_value_r;
    new_unknown = chunk_unknown_r | ~bd[3];
    new_length  = chunk_length_r + 3'd1;
    emit        = (new_length >= eff_k) || in_item.last_symbol;

    chunk_value_nxt   = chunk_value_r;
    chunk_length_nxt  = chunk_length_r;
    chunk_unknown_nxt = chunk_unknown_r;
    push              = '0;

    if (accept) begin
      if (sp[3]) begin
        chunk_value_nxt   = '0;
        chunk_length_nxt  = '0;
        chunk_unknown_nxt = 1'b0;
        if (chunk_length_r != 3'd0) begin
          push.push0        = 1'b1;
          push.push1        = 1'b1;
          push.entry0.token_id = kte_pkg::chunk_id(chunk_value_r, chunk_length_r,
                                                   chunk_unknown_r);
          push.entry1.token_id = {13'd0, sp[2:0]};
          push.entry1.last_of_run     = 1'b1;
          push.entry1.end_of_sequence = in_item.last_symbol;
        end else begin
          push.push0                  = 1'b1;
          push.entry0.token_id        = {13'd0, sp[2:0]};
          push.entry0.last_of_run     = 1'b1;
          push.entry0.end_of_sequence = in_item.last_symbol;
        end
      end else if (emit) begin
        chunk_value_nxt             = '0;
        chunk_length_nxt            = '0;
        chunk_unknown_nxt           = 1'b0;
        push.push0                  = 1'b1;
        push.entry0.token_id        = kte_pkg::chunk_id(new_value, new_length, new_unknown);
        push.entry0.last_of_run     = 1'b1;
        push.entry0.end_of_sequence = in_item.last_symbol;
      end else begin
        chunk_value_nxt   = new_value;
        chunk_length_nxt  = new_length;
        chunk_unknown_nxt = new_unknown;
      end
    end

    // a k_size write drops the pending chunk
    if (cfg_clear) begin
      chunk_value_nxt   = '0;
      chunk_length_nxt  = '0;
      chunk_unknown_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_value_r   <= '0;
      chunk_length_r  <= '0;
      chunk_unknown_r <= 1'b0;
    end else begin
      chunk_value_r   <= chunk_value_nxt;
      chunk_length_r  <= chunk_length_nxt;
      chunk_unknown_r <= chunk_unknown_nxt;
    end
  end

endmodule

### hdl/kte_queue.sv
module kte_queue #(
  parameter int DEPTH = kte_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kte_pkg::push_t push,
  input  logic           pop,
  output kte_pkg::out_t  head,
  output logic           not_empty,
  output logic           room2
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  kte_pkg::out_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_1, wr_ptr_2;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_1 = inc(wr_ptr_r);
    wr_ptr_2 = inc(wr_ptr_1);

    if (push.push1) begin
      wr_ptr_nxt = wr_ptr_2;
    end else if (push.push0) begin
      wr_ptr_nxt = wr_ptr_1;
    end else begin
      wr_ptr_nxt = wr_ptr_r;
    end

    rd_ptr_nxt = pop ? inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.entry0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_1] <= push.entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/kte_back.sv
module kte_back (
  input  logic          clk,
  input  logic          rst_n,
  input  kte_pkg::out_t head,
  input  logic          not_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output kte_pkg::out_t out_data
);

  logic          out_valid_r;
  kte_pkg::out_t out_data_r;

  // refill the output register whenever it is empty or being taken
  assign pop = not_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/dna_kmer_token_encoder.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_data   (symbol, last_symbol)
// out_      output     out_valid/out_stall  out_data  (token_id, last_of_run, end_of_sequence)
// config    APB write  psel/penable/pwrite  paddr, pwdata, prdata (k_size at 0)
//
// One request is taken per cycle while in_stall is low; results leave through one output
// register at one per cycle while out_stall is low, so a request that closes a chunk and
// carries a special symbol yields two results and the result queue absorbs the extra one.
// A result passes through the result queue and then the output register to reach out_.
// in_stall rises when the result queue has fewer than two free slots.
// Synchronous reset: k_size 4, no pending chunk, queue and output register empty.
module dna_kmer_token_encoder #(
  parameter int QUEUE_DEPTH = kte_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  kte_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output kte_pkg::out_t                      out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kte_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [kte_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [kte_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic [2:0]     k_size_r;
  logic           cfg_write;
  logic           accept;
  logic           room2;
  logic           not_empty;
  logic           pop;
  kte_pkg::push_t push;
  kte_pkg::out_t  head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == kte_pkg::REG_K_SIZE);
  assign prdata    = (paddr[2] == kte_pkg::REG_K_SIZE) ? {29'd0, k_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_size_r <= kte_pkg::K_SIZE_RESET;
    end else if (cfg_write) begin
      k_size_r <= pwdata[2:0];
    end
  end

  assign in_stall = !room2;
  assign accept   = in_valid && room2;

  kte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .k_size    (k_size_r),
    .cfg_clear (cfg_write),
    .push      (push)
  );

  kte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  kte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
